FILE: rtl/nzp_pkg.sv
package nzp_pkg;

    localparam int MAX_ZONES = 32;
    localparam int MAX_DEPTH = 16;
    localparam int ZW = $clog2(MAX_ZONES);
    localparam int DW = $clog2(MAX_DEPTH);
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_FBEGIN = 2'd2;
    localparam logic [1:0] MODE_FEND   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_IGN    = 2'd1;
    localparam logic [1:0] ST_OVF    = 2'd2;
    localparam logic [1:0] ST_FRAME  = 2'd3;

    localparam logic [0:0] REG_ENABLE = 1'b0;
    localparam logic [0:0] REG_ZONES  = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  zone_id;
        logic [63:0] timestamp;
    } nzp_in_t;

    typedef struct packed {
        logic [5:0]  rpt_zone;
        logic [1:0]  status;
        logic [31:0] elapsed_ticks;
        logic [31:0] inclusive;
        logic [31:0] exclusive;
        logic [31:0] calls;
        logic [31:0] frames_seen;
        logic [31:0] incl_min;
        logic [31:0] incl_max;
        logic [63:0] incl_sum;
        logic        last;
    } nzp_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          load;      // capture input item
        logic          search;    // step the stack search down one entry
        logic          exec;      // read-modify-write of the zone record
        logic          fold;      // frame-end fold of zone at scan index
        logic          clear;     // frame-begin clear of zone at scan index
        logic [ZW-1:0] scan;
    } nzp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       quick;      // disabled or out-of-range: emit ignore at once
        logic       found;      // search hit
        logic       miss;       // search exhausted
        logic [6:0] live;
    } nzp_stat_t;

endpackage

FILE: rtl/nested_zone_profiler.sv
// Nested zone profiler.
// Input channel s_valid/s_ready/s_data carries one event transaction: a mode
// (zone begin, zone end, frame begin, frame end), a zone index and a timestamp.
// Result channel m_valid/m_ready/m_data carries the result transactions that
// the event causes; m_data.last marks the final one.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set enable and
// zones_in_use and must be issued only while no event is in flight.
// A begin or an ignored event is loaded, decoded and executed; its result is
// then registered in the output register. A zone end searches the open-zone
// stack one entry a cycle from the top before it executes. A frame begin clears
// one live zone a cycle while the output register is free, then answers once.
// A frame end emits one result per live zone (one with no live zones), one a
// cycle while the output register is free. A new event is taken only once the
// last is through: load, decode and at least one update step, before the
// controller is ready again.
// Reset (aresetn low, synchronous) empties the stack, clears the statistics
// and the overflow count, and sets enable to one.
// When the receiver stalls, the result waits in the output register and the
// controller holds; no result is lost.
module nested_zone_profiler import nzp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [5:0] cfg_index,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  nzp_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output nzp_out_t   m_data
);

    nzp_cmd_t  cmd;
    nzp_stat_t stat;
    nzp_out_t  res;
    logic      emit, emit_last;
    logic      m_valid_reg;
    nzp_out_t  m_data_reg;
    logic      out_busy;

    // The output register is free when empty or being drained this cycle.
    assign out_busy = m_valid_reg && !m_ready;

    nzp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .out_busy(out_busy), .stat(stat), .cmd(cmd), .emit(emit),
        .emit_last(emit_last)
    );

    nzp_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we),
        .cfg_index(cfg_index[0]), .cfg_addr_ok(cfg_index[5:1] == 5'd0),
        .cfg_data(cfg_wdata), .s_data(s_data), .cmd(cmd), .emit(emit),
        .emit_last(emit_last), .stat(stat), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/nzp_ctrl.sv
module nzp_ctrl import nzp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      out_busy,
    input  nzp_stat_t stat,
    output nzp_cmd_t  cmd,
    output logic      emit,
    output logic      emit_last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [ZW:0]   idx_reg, idx_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.scan   = idx_reg[ZW-1:0];
        emit       = 1'b0;
        emit_last  = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                idx_next = '0;
                if (stat.quick || stat.mode == MODE_BEGIN) begin
                    state_next = S_EXEC;
                end else if (stat.mode == MODE_END) begin
                    state_next = S_SEARCH;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                if (stat.found || stat.miss) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!out_busy) begin
                    cmd.exec   = 1'b1;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!out_busy) begin
                    emit = 1'b1;
                    if (stat.mode == MODE_FBEGIN || stat.live == '0) begin
                        cmd.clear  = (stat.mode == MODE_FBEGIN);
                        if (stat.mode == MODE_FBEGIN && {1'b0, idx_reg} + 8'd1 < {1'b0, stat.live}) begin
                            emit     = 1'b0;
                            idx_next = idx_reg + 1'b1;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        cmd.fold  = 1'b1;
                        emit_last = ({1'b0, idx_reg} + 8'd1 == {1'b0, stat.live});
                        idx_next  = idx_reg + 1'b1;
                        if (emit_last) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !out_busy) else $error("result issued into a full output stage");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready) else $error("second item taken while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fold && cmd.clear) == 1'b0) else $error("fold and clear together");

endmodule

FILE: rtl/nzp_dp.sv
module nzp_dp import nzp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic      cfg_addr_ok,
    input  logic [5:0] cfg_data,
    input  nzp_in_t   s_data,
    input  nzp_cmd_t  cmd,
    input  logic      emit,
    input  logic      emit_last,
    output nzp_stat_t stat,
    output nzp_out_t  res
);

    logic          enable_reg;
    logic [5:0]    zones_reg;
    nzp_in_t       item_reg;
    logic [DW:0]   depth_reg;
    logic [DW:0]   at_reg;
    logic [31:0]   ovf_reg;
    logic [1:0]    status_reg;
    logic [31:0]   elapsed_reg;
    logic          hit_reg;

    logic [5:0]    sid   [MAX_DEPTH];
    logic [63:0]   sst   [MAX_DEPTH];
    logic [31:0]   sch   [MAX_DEPTH];

    logic [31:0]   z_inc [MAX_ZONES];
    logic [31:0]   z_exc [MAX_ZONES];
    logic [31:0]   z_cal [MAX_ZONES];
    logic [31:0]   z_frm [MAX_ZONES];
    logic [31:0]   z_min [MAX_ZONES];
    logic [31:0]   z_max [MAX_ZONES];
    logic [63:0]   z_tot [MAX_ZONES];

    logic [6:0]    live;
    logic          in_range;
    logic [ZW-1:0] zi;
    logic [DW-1:0] top;
    logic [63:0]   diff;
    logic [31:0]   el;
    logic [31:0]   child;
    logic [31:0]   cmin;
    logic [ZW-1:0] ri;
    logic          stats;

    assign live     = (zones_reg > 6'(MAX_ZONES)) ? 7'(MAX_ZONES) : {1'b0, zones_reg};
    assign in_range = {1'b0, item_reg.zone_id} < live;
    assign zi       = item_reg.zone_id[ZW-1:0];
    assign top      = DW'(at_reg - 1'b1);
    assign diff     = item_reg.timestamp - sst[top];
    assign el       = (diff > {32'd0, SAT32}) ? SAT32 : diff[31:0];
    assign child    = sch[top];
    assign cmin     = (child > el) ? el : child;

    assign stat.mode  = item_reg.mode;
    assign stat.quick = !enable_reg ||
        ((item_reg.mode == MODE_BEGIN || item_reg.mode == MODE_END) && !in_range);
    assign stat.found = (at_reg != '0) && (sid[top] == item_reg.zone_id);
    assign stat.miss  = (at_reg == '0);
    assign stat.live  = live;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            zones_reg  <= '0;
            depth_reg  <= '0;
            ovf_reg    <= '0;
            for (int i = 0; i < MAX_ZONES; i++) begin
                z_inc[i] <= '0; z_exc[i] <= '0; z_cal[i] <= '0; z_frm[i] <= '0;
                z_min[i] <= SAT32; z_max[i] <= '0; z_tot[i] <= '0;
            end
        end else begin
            if (cfg_we && cfg_addr_ok) begin
                if (cfg_index == REG_ENABLE) enable_reg <= cfg_data[0];
                else zones_reg <= cfg_data;
            end
            if (cmd.load) begin
                item_reg    <= s_data;
                at_reg      <= depth_reg;
                elapsed_reg <= '0;
                hit_reg     <= 1'b0;
            end
            if (cmd.search && !stat.found && !stat.miss) at_reg <= at_reg - 1'b1;
            if (cmd.search && stat.found) begin
                hit_reg     <= 1'b1;
                elapsed_reg <= el;
            end
            if (cmd.exec && !stat.quick) begin
                if (item_reg.mode == MODE_BEGIN) begin
                    if (depth_reg >= (DW+1)'(MAX_DEPTH)) begin
                        ovf_reg <= ovf_reg + 1'b1;
                    end else begin
                        sid[depth_reg[DW-1:0]] <= item_reg.zone_id;
                        sst[depth_reg[DW-1:0]] <= item_reg.timestamp;
                        sch[depth_reg[DW-1:0]] <= '0;
                        depth_reg <= depth_reg + 1'b1;
                    end
                end else if (hit_reg) begin
                    depth_reg <= at_reg - 1'b1;
                    if (z_cal[zi] == '0) z_frm[zi] <= z_frm[zi] + 1'b1;
                    z_cal[zi] <= z_cal[zi] + 1'b1;
                    z_inc[zi] <= z_inc[zi] + elapsed_reg;
                    z_exc[zi] <= z_exc[zi] + (elapsed_reg - cmin);
                    if (at_reg > (DW+1)'(1)) begin
                        sch[DW'(at_reg - 2'd2)] <= sch[DW'(at_reg - 2'd2)] + elapsed_reg;
                    end
                end
            end
            // The stack empties on every frame begin; only live zones are cleared.
            if (cmd.clear) begin
                if ({2'b00, cmd.scan} < live) begin
                    z_inc[cmd.scan] <= '0; z_exc[cmd.scan] <= '0; z_cal[cmd.scan] <= '0;
                end
                depth_reg <= '0;
            end
            if (cmd.fold && z_cal[cmd.scan] != '0) begin
                if (z_inc[cmd.scan] < z_min[cmd.scan]) z_min[cmd.scan] <= z_inc[cmd.scan];
                if (z_inc[cmd.scan] > z_max[cmd.scan]) z_max[cmd.scan] <= z_inc[cmd.scan];
                z_tot[cmd.scan] <= z_tot[cmd.scan] + {32'd0, z_inc[cmd.scan]};
            end
        end
    end

    // Result assembly: post-update values for a fold are formed here combinationally.
    logic [31:0] nmin, nmax;
    logic [63:0] ntot;
    logic        fc;
    always_comb begin
        ri    = cmd.fold ? cmd.scan : zi;
        fc    = cmd.fold && z_cal[ri] != '0;
        nmin  = (fc && z_inc[ri] < z_min[ri]) ? z_inc[ri] : z_min[ri];
        nmax  = (fc && z_inc[ri] > z_max[ri]) ? z_inc[ri] : z_max[ri];
        ntot  = fc ? z_tot[ri] + {32'd0, z_inc[ri]} : z_tot[ri];
        res   = '0;
        stats = 1'b0;
        res.last = emit_last;
        if (stat.quick) begin
            res.rpt_zone = item_reg.zone_id;
            res.status   = ST_IGN;
        end else if (item_reg.mode == MODE_FEND) begin
            res.status = ST_FRAME;
            if (live != '0) begin
                res.rpt_zone = 6'(cmd.scan);
                stats = 1'b1;
            end
        end else if (item_reg.mode == MODE_FBEGIN) begin
            res.status = ST_FRAME;
        end else begin
            res.rpt_zone = item_reg.zone_id;
            stats = 1'b1;
            if (item_reg.mode == MODE_BEGIN) begin
                res.status = (depth_reg >= (DW+1)'(MAX_DEPTH)) ? ST_OVF : ST_OK;
            end else begin
                res.status        = hit_reg ? ST_OK : ST_IGN;
                res.elapsed_ticks = elapsed_reg;
            end
        end
        if (stats) begin
            res.inclusive   = z_inc[ri];
            res.exclusive   = z_exc[ri];
            res.calls       = z_cal[ri];
            res.frames_seen = z_frm[ri];
            res.incl_min    = nmin;
            res.incl_max    = nmax;
            res.incl_sum    = ntot;
            if (!cmd.fold && item_reg.mode == MODE_END && hit_reg) begin
                res.calls     = z_cal[ri] + 1'b1;
                res.frames_seen = (z_cal[ri] == '0) ? z_frm[ri] + 1'b1 : z_frm[ri];
                res.inclusive = z_inc[ri] + elapsed_reg;
                res.exclusive = z_exc[ri] + (elapsed_reg - cmin);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= (DW+1)'(MAX_DEPTH)) else $error("stack depth beyond limit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search |-> at_reg <= depth_reg) else $error("search pointer above top");
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !(cmd.fold && cmd.exec)) else $error("two updates in one cycle");

endmodule
